/* hdl/npcs_pkg.sv */
package npcs_pkg;

  // Field widths of the stream payload.
  localparam int CH_W        = 8;
  localparam int IDX_FIELD_W = 8;
  localparam int DIST_W      = 18;
  localparam int SQ_W        = 2 * CH_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // Default palette depth.
  localparam int PALETTE_ENTRIES_DEF = 256;

  // Running minimum starts above every reachable distance (3 * 256 * 256).
  localparam logic [DIST_W-1:0] START_DISTANCE = 18'd196608;

  // Largest distance a result can carry (3 * 255 * 255).
  localparam logic [DIST_W-1:0] MAX_DISTANCE = 18'd195075;

  // Item kinds carried on tuser.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } npcs_state_t;

endpackage

/* hdl/nearest_palette_color_search_core.sv */
// Load item: no result; the next item may follow at once.
// Query item: the scan walks every palette entry, and the sequencer returns to idle
// and opens the input at the same edge that loads the result into the output
// register, which waits while an earlier result is still stalled there.
// The scan reads one entry per cycle through the single palette read port.
// Reset (rst_n low at a clock edge) clears control state; the palette is not cleared.
module nearest_palette_color_search_core #(
  parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata, lowest bit up: entry_index[7:0], red[15:8], green[23:16], blue[31:24].
  input  logic [npcs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: cmd[0] (0 loads a palette entry, 1 queries the nearest entry).
  input  logic                               in_tuser,
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, lowest bit up: nearest_index[7:0], nearest_distance[25:8], zeros[31:26].
  output logic [npcs_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // Address width of the palette store.
  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
  localparam int CH_W   = npcs_pkg::CH_W;
  localparam int SQ_W   = npcs_pkg::SQ_W;
  localparam int DIST_W = npcs_pkg::DIST_W;

  // Unpack the input item.
  logic [npcs_pkg::IDX_FIELD_W-1:0] in_entry_index;
  logic [CH_W-1:0]                  in_red;
  logic [CH_W-1:0]                  in_green;
  logic [CH_W-1:0]                  in_blue;

  assign in_entry_index = in_tdata[7:0];
  assign in_red         = in_tdata[15:8];
  assign in_green       = in_tdata[23:16];
  assign in_blue        = in_tdata[31:24];

  logic in_accept;
  assign in_accept = in_tvalid && in_tready;

  // A load item beyond the palette depth is dropped. The index is widened so
  // that depths above 256 still take the 8-bit field as a zero-extended address.
  logic [IDX_W+7:0] wr_idx_wide;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_in_range;
  logic             wr_en;

  assign wr_idx_wide = {{IDX_W{1'b0}}, in_entry_index};
  assign wr_addr     = wr_idx_wide[IDX_W-1:0];
  assign wr_in_range = ({24'd0, in_entry_index} < 32'(PALETTE_ENTRIES));
  assign wr_en       = in_accept && (in_tuser == npcs_pkg::CMD_LOAD) && wr_in_range;

  // Sequencer state and its decoded controls.
  npcs_pkg::npcs_state_t state_r;
  npcs_pkg::npcs_state_t state_nxt;

  logic        scan_issue;   // read the entry at cnt_r this cycle
  logic        out_load;     // move the final minimum into the output register
  logic        done_r;       // the last entry has been folded into the minimum
  logic        out_free;

  logic [IDX_W-1:0] cnt_r;
  logic             cnt_last;

  assign cnt_last = (cnt_r == LAST_IDX);
  assign out_free = !out_tvalid || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      npcs_pkg::ST_IDLE: begin
        if (in_accept && (in_tuser == npcs_pkg::CMD_QUERY)) begin
          state_nxt = npcs_pkg::ST_SCAN;
        end
      end
      npcs_pkg::ST_SCAN: begin
        if (cnt_last) begin
          state_nxt = npcs_pkg::ST_FINISH;
        end
      end
      npcs_pkg::ST_FINISH: begin
        if (done_r && out_free) begin
          state_nxt = npcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = npcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    scan_issue = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      npcs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      npcs_pkg::ST_SCAN: begin
        scan_issue = 1'b1;
      end
      npcs_pkg::ST_FINISH: begin
        out_load = done_r && out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npcs_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        cnt_r <= '0;
      end else if (scan_issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Query color, held for the whole scan.
  logic [CH_W-1:0] q_red_r;
  logic [CH_W-1:0] q_green_r;
  logic [CH_W-1:0] q_blue_r;

  always_ff @(posedge clk) begin
    if (in_accept && (in_tuser == npcs_pkg::CMD_QUERY)) begin
      q_red_r   <= in_red;
      q_green_r <= in_green;
      q_blue_r  <= in_blue;
    end
  end

  // Palette store: one write port for load items, one registered read port
  // that the scan walks in index order.
  logic [3*CH_W-1:0] palette_mem [PALETTE_ENTRIES];
  logic [3*CH_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_mem[wr_addr] <= {in_red, in_green, in_blue};
    end
    if (scan_issue) begin
      rd_data_r <= palette_mem[cnt_r];
    end
  end

  // Pipeline tags that follow each entry through the distance unit.
  logic             rd_vld_r;
  logic             rd_last_r;
  logic [IDX_W-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_last_r <= cnt_last;
      rd_idx_r  <= cnt_r;
    end
  end

  // First half of the distance unit: per-channel absolute difference and square.
  logic [CH_W-1:0] e_red;
  logic [CH_W-1:0] e_green;
  logic [CH_W-1:0] e_blue;
  logic [CH_W-1:0] d_red;
  logic [CH_W-1:0] d_green;
  logic [CH_W-1:0] d_blue;

  assign e_red   = rd_data_r[3*CH_W-1:2*CH_W];
  assign e_green = rd_data_r[2*CH_W-1:CH_W];
  assign e_blue  = rd_data_r[CH_W-1:0];

  assign d_red   = (e_red   > q_red_r)   ? (e_red   - q_red_r)   : (q_red_r   - e_red);
  assign d_green = (e_green > q_green_r) ? (e_green - q_green_r) : (q_green_r - e_green);
  assign d_blue  = (e_blue  > q_blue_r)  ? (e_blue  - q_blue_r)  : (q_blue_r  - e_blue);

  logic [SQ_W-1:0]  sq_red_r;
  logic [SQ_W-1:0]  sq_green_r;
  logic [SQ_W-1:0]  sq_blue_r;
  logic             sq_vld_r;
  logic             sq_last_r;
  logic [IDX_W-1:0] sq_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      sq_red_r   <= SQ_W'(d_red)   * SQ_W'(d_red);
      sq_green_r <= SQ_W'(d_green) * SQ_W'(d_green);
      sq_blue_r  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
      sq_last_r  <= rd_last_r;
      sq_idx_r   <= rd_idx_r;
    end
  end

  // Second half: sum and strict less-than against the running minimum, so the
  // lowest index keeps a tie.
  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              take;

  assign dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);
  assign take     = sq_vld_r && (dist_sum < best_dist_r);

  always_ff @(posedge clk) begin
    if (in_accept && (in_tuser == npcs_pkg::CMD_QUERY)) begin
      best_dist_r <= npcs_pkg::START_DISTANCE;
      best_idx_r  <= '0;
    end else if (take) begin
      best_dist_r <= dist_sum;
      best_idx_r  <= sq_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (out_load) begin
      done_r <= 1'b0;
    end else if (sq_vld_r && sq_last_r) begin
      done_r <= 1'b1;
    end
  end

  // Output register: a finished result waits here while the sequencer returns
  // to idle and takes the next item.
  logic [IDX_W+7:0] best_idx_wide;
  assign best_idx_wide = {8'd0, best_idx_r};

  logic                            out_valid_r;
  logic [npcs_pkg::IDX_FIELD_W-1:0] out_index_r;
  logic [DIST_W-1:0]               out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= best_idx_wide[7:0];
      out_dist_r  <= best_dist_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_dist_r, out_index_r};

endmodule

/* hdl/npcs_checker.sv */
module npcs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [npcs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [npcs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or vanished while stalled");

  // A result carries a reachable distance and zero padding.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[25:8] <= npcs_pkg::MAX_DISTANCE) && (out_tdata[31:26] == 6'd0))
    else $error("result distance out of range or padding not zero");

  // A query starts a scan, so the input side closes in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == npcs_pkg::CMD_QUERY) |=> !in_tready)
    else $error("input accepted right after a query");

  // A load item leaves the input side open.
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == npcs_pkg::CMD_LOAD) |=> in_tready)
    else $error("input closed after a load item");

endmodule

bind nearest_palette_color_search_core npcs_checker u_npcs_checker (.*);

/* test/tb_nearest_palette_color_search_core.sv */
`timescale 1ns / 100ps

// Stream-level testbench for the nearest palette color search core.
// A small class keeps a shadow of the palette and predicts, for every accepted
// query item, the index and squared distance of the closest palette entry.
// Results are checked in order against that prediction.
module tb_nearest_palette_color_search_core;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int HOLD_AFTER   = 25;
  localparam int DRAIN_CYCLES = 300;
  localparam int IDLE_PERCENT = 13;
  localparam int REFILL_ITEMS = 128;
  localparam int MIXED_ITEMS  = 150;
  localparam int MAX_REPORTS  = 10;

  // Expected outcome of one query: the winning entry and its distance.
  typedef struct packed {
    logic [npcs_pkg::IDX_FIELD_W-1:0] index;
    logic [npcs_pkg::DIST_W-1:0]      distance;
  } color_match_t;

  // Shadow palette plus the queue of matches still owed by the block.
  class nearest_color_tracker;
    logic [3*npcs_pkg::CH_W-1:0] palette [npcs_pkg::PALETTE_ENTRIES_DEF];
    color_match_t awaited_matches [$];
    int loads_seen;
    int queries_seen;
    int results_checked;
    int failures;

    function new();
      foreach (palette[i]) palette[i] = '0;
      loads_seen      = 0;
      queries_seen    = 0;
      results_checked = 0;
      failures        = 0;
    endfunction

    function int pending();
      return awaited_matches.size();
    endfunction

    function void note_failure(string what);
      if (failures < MAX_REPORTS) $display("MISMATCH: %s", what);
      failures++;
    endfunction

    // Scans the palette in index order; strict less-than keeps the lowest index.
    function color_match_t closest_entry(logic [npcs_pkg::CH_W-1:0] red,
                                         logic [npcs_pkg::CH_W-1:0] green,
                                         logic [npcs_pkg::CH_W-1:0] blue);
      color_match_t best;
      int unsigned  best_dist;
      int unsigned  dist_sum;
      int           dr;
      int           dg;
      int           db;
      best_dist  = npcs_pkg::START_DISTANCE;
      best.index = '0;
      for (int i = 0; i < npcs_pkg::PALETTE_ENTRIES_DEF; i++) begin
        dr       = int'(palette[i][23:16]) - int'(red);
        dg       = int'(palette[i][15:8]) - int'(green);
        db       = int'(palette[i][7:0]) - int'(blue);
        dist_sum = dr * dr + dg * dg + db * db;
        if (dist_sum < best_dist) begin
          best_dist  = dist_sum;
          best.index = npcs_pkg::IDX_FIELD_W'(i);
        end
      end
      best.distance = npcs_pkg::DIST_W'(best_dist);
      return best;
    endfunction

    function void record_item(logic cmd, logic [npcs_pkg::IN_TDATA_W-1:0] word);
      if (cmd == npcs_pkg::CMD_LOAD) begin
        palette[word[7:0]] = {word[15:8], word[23:16], word[31:24]};
        loads_seen++;
      end else begin
        awaited_matches.push_back(closest_entry(word[15:8], word[23:16], word[31:24]));
        queries_seen++;
      end
    endfunction

    function void check_result(logic [npcs_pkg::OUT_TDATA_W-1:0] word);
      color_match_t want;
      results_checked++;
      if (awaited_matches.size() == 0) begin
        note_failure($sformatf("unexpected result: index %0d distance %0d",
                               word[7:0], word[25:8]));
        return;
      end
      want = awaited_matches.pop_front();
      if (word[7:0] !== want.index)
        note_failure($sformatf("result %0d: nearest_index expected %0d, got %0d",
                               results_checked, want.index, word[7:0]));
      if (word[25:8] !== want.distance)
        note_failure($sformatf("result %0d: nearest_distance expected %0d, got %0d",
                               results_checked, want.distance, word[25:8]));
      if (word[31:26] !== '0)
        note_failure($sformatf("result %0d: padding bits expected 0, got %b",
                               results_checked, word[31:26]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [npcs_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = npcs_pkg::CMD_LOAD;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [npcs_pkg::OUT_TDATA_W-1:0] out_tdata;

  nearest_color_tracker sb;
  int cycle_count = 0;
  // While set, neither side inserts idle cycles.
  bit no_idle = 1'b0;
  bit hold_done = 1'b0;

  nearest_palette_color_search_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // in_tdata, lowest bit up: entry_index, red, green, blue.
    .in_tdata   (in_tdata),
    // in_tuser: cmd (load or query).
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // out_tdata, lowest bit up: nearest_index, nearest_distance, zero padding.
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Both channels are sampled at the clock edge, so the values seen here are the
  // ones the block itself acts on in this cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.record_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Every channel of the returned color is either fully dark or fully lit.
  function automatic logic [23:0] extreme_color();
    logic [23:0] color;
    color = '0;
    for (int s = 0; s < 3; s++) begin
      if ($urandom_range(1)) color[8*s +: 8] = 8'hFF;
    end
    return color;
  endfunction

  // Moves each channel by up to two steps, clamped, so the query lands close to
  // an entry and near-ties between neighbors become likely.
  function automatic logic [23:0] nudge(logic [23:0] color);
    int c;
    for (int s = 0; s < 3; s++) begin
      c = int'(color[8*s +: 8]) + int'($urandom_range(4)) - 2;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      color[8*s +: 8] = 8'(c);
    end
    return color;
  endfunction

  // Offers one item and holds it until the block takes it. Idle cycles are added
  // afterwards, so tvalid is only lowered when a real gap follows.
  task automatic send_item(logic cmd, logic [7:0] slot, logic [23:0] color);
    in_tuser  <= cmd;
    in_tdata  <= {color[7:0], color[15:8], color[23:16], slot};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stops offering items until every outstanding query has produced its result.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side. Once a couple dozen results are in, the receiver refuses
  // results for a long stretch while the sender keeps offering, so a finished
  // query backs up and the input channel stalls behind it.
  initial begin
    int held_cycles;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && sb.results_checked >= HOLD_AFTER) begin
        hold_done   = 1'b1;
        held_cycles = 0;
        out_tready <= 1'b0;
        while (held_cycles < HOLD_CYCLES) begin
          @(posedge clk);
          held_cycles++;
          out_tready <= 1'b0;
        end
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, sb.pending());
    $display("tb_nearest_palette_color_search_core NOT OK");
    $finish;
  end

  initial begin
    logic [23:0] cluster [16];
    logic [23:0] color;
    int unsigned roll;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The palette has no reset value, so every entry is written before the
    // first query. Starting from all black makes the early queries easy to
    // reason about.
    for (int i = 0; i < npcs_pkg::PALETTE_ENTRIES_DEF; i++)
      send_item(npcs_pkg::CMD_LOAD, 8'(i), 24'h000000);

    // Directed part. With every entry black, a white query sits at the largest
    // possible distance and ties across the whole palette, so index 0 must win.
    send_item(npcs_pkg::CMD_QUERY, 8'h00, 24'hFFFFFF);
    send_item(npcs_pkg::CMD_QUERY, 8'hFF, 24'h000000);
    // A lone match in the last entry.
    send_item(npcs_pkg::CMD_LOAD, 8'd255, 24'hFFFFFF);
    send_item(npcs_pkg::CMD_QUERY, 8'h5A, 24'hFFFFFF);
    // A second white entry at a lower index takes over the tie.
    send_item(npcs_pkg::CMD_LOAD, 8'd128, 24'hFFFFFF);
    send_item(npcs_pkg::CMD_QUERY, 8'hA5, 24'hFEFEFE);
    // Pure primaries in the first entries, each queried exactly.
    send_item(npcs_pkg::CMD_LOAD, 8'd0, 24'hFF0000);
    send_item(npcs_pkg::CMD_LOAD, 8'd1, 24'h00FF00);
    send_item(npcs_pkg::CMD_LOAD, 8'd2, 24'h0000FF);
    send_item(npcs_pkg::CMD_QUERY, 8'h00, 24'hFF0000);
    send_item(npcs_pkg::CMD_QUERY, 8'h00, 24'h00FF00);
    send_item(npcs_pkg::CMD_QUERY, 8'h00, 24'h0000FF);
    // Mid gray lies between black and white; then a closer gray appears, and
    // finally an equal gray at a lower index must win the tie.
    send_item(npcs_pkg::CMD_QUERY, 8'h33, 24'h808080);
    send_item(npcs_pkg::CMD_LOAD, 8'd77, 24'h7F7F7F);
    send_item(npcs_pkg::CMD_QUERY, 8'h44, 24'h808080);
    send_item(npcs_pkg::CMD_LOAD, 8'd3, 24'h7F7F7F);
    send_item(npcs_pkg::CMD_QUERY, 8'hC3, 24'h808080);
    send_item(npcs_pkg::CMD_QUERY, 8'hFF, 24'h00FFFF);
    wait_for_results();

    // Rewrite every even entry. Half of them come from a small set of colors,
    // so duplicate entries and ties are common in the random part.
    for (int i = 0; i < 16; i++) cluster[i] = 24'($urandom);
    for (int i = 0; i < REFILL_ITEMS; i++) begin
      color = $urandom_range(1) ? cluster[$urandom_range(15)] : 24'($urandom);
      send_item(npcs_pkg::CMD_LOAD, 8'(2 * i), color);
    end

    // Mixed random part: loads overwrite entries while queries hit exact
    // entries, near neighbors, corner colors and arbitrary colors.
    for (int k = 0; k < MIXED_ITEMS; k++) begin
      no_idle = (k >= 70 && k < 130);
      if (k == 60) wait_for_results();
      roll = $urandom_range(99);
      if (roll < 40) begin
        roll = $urandom_range(99);
        if (roll < 40) color = sb.palette[$urandom_range(255)];
        else if (roll < 55) color = extreme_color();
        else color = 24'($urandom);
        send_item(npcs_pkg::CMD_LOAD, 8'($urandom_range(255)), color);
      end else begin
        roll = $urandom_range(99);
        if (roll < 15) color = sb.palette[$urandom_range(255)];
        else if (roll < 35) color = nudge(sb.palette[$urandom_range(255)]);
        else if (roll < 45) color = extreme_color();
        else color = 24'($urandom);
        send_item(npcs_pkg::CMD_QUERY, 8'($urandom), color);
      end
    end
    no_idle = 1'b0;

    // Let the last query finish, then leave room for anything stray.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.note_failure($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Covered %0d palette loads and %0d nearest-entry queries, including ties,",
             sb.loads_seen, sb.queries_seen);
    $display("exact hits, corner colors and the largest distance; %0d results, %0d failures.",
             sb.results_checked, sb.failures);
    if (sb.failures == 0) begin
      $display("tb_nearest_palette_color_search_core OK");
    end else begin
      $display("tb_nearest_palette_color_search_core NOT OK");
    end
    $finish;
  end

endmodule

/* nearest_palette_color_search_core.f */
hdl/npcs_pkg.sv
hdl/nearest_palette_color_search_core.sv
hdl/npcs_checker.sv
test/tb_nearest_palette_color_search_core.sv
